// ===== hw/rtl/wpic_pkg.sv =====
// wpic_pkg: shared types and constants of the wheel phase integral controller
// used by wheel_phase_integral_controller, no dependencies

package wpic_pkg;

  // design defaults
  localparam int HOLDER_COUNT_DEF = 4;

  // fixed-point constants, 16 fraction bits
  localparam int MIN_SPEED_Q16  = 1639;      // 0.025 m/s rounded up
  localparam int DEADBAND_Q16   = 3276;      // 0.05 degrees
  localparam int HALF_TURN_Q16  = 11796480;  // 180 degrees
  localparam int FULL_TURN_Q16  = 23592960;  // 360 degrees
  localparam int RESET_CURRENT  = 9830400;   // 150 mA in Q12.16
  localparam int ROUND_HALF_Q16 = 32768;
  localparam int DRIVE_MAX      = 4095;

  // field widths
  localparam int SPEED_W   = 24;
  localparam int ANGLE_W   = 25;
  localparam int CUR_W     = 12;
  localparam int WANT_W    = 24;
  localparam int TARGET_W  = 28;
  localparam int CFG24_W   = 24;
  localparam int DVD_W     = 47;  // speed * 36 * 2^16 + den / 2
  localparam int DIV_STEPS = 24;
  localparam int CNT_W     = 5;
  localparam int ERR_W     = 26;
  localparam int MAG_W     = 25;
  localparam int PROD_W    = 49;
  localparam int INC_W     = 34;
  localparam int ACC_W     = 36;

  // register map, byte address is 4 * index
  localparam int PADDR_W = 5;
  localparam logic [2:0] REG_PERIMETER = 3'd0;
  localparam logic [2:0] REG_DISTANCE  = 3'd1;
  localparam logic [2:0] REG_GAIN      = 3'd2;
  localparam logic [2:0] REG_FLOOR     = 3'd3;
  localparam logic [2:0] REG_CEILING   = 3'd4;

  localparam logic [11:0] FLOOR_RST   = 12'd350;
  localparam logic [11:0] CEILING_RST = 12'd2000;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } wpic_state_e;

endpackage

// ===== hw/rtl/wheel_phase_integral_controller.sv =====
// wheel_phase_integral_controller: per-tick angle tracking and valve current integrator
// one shared subtract/compare unit serves the saturation check and a restoring divider
// depends on wpic_pkg
//
// sequence: a gated, priming or unconfigured tick goes from accept straight to output;
//   an updating tick runs prep, saturation check, 24 divider steps, multiply,
//   accumulate, output; the divider steps are skipped when the wanted change saturates;
//   the divider loop yields one quotient bit per cycle
// flow: words are taken only in idle, but the next word is taken while a result waits
// reset: rst_ni resets control and config registers, target current to 150 mA, unprimed

module wheel_phase_integral_controller #(
  parameter int HOLDER_COUNT = wpic_pkg::HOLDER_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave side
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // ground_speed[23:0], wheel_angle[48:24], run_enable[49], estop_ok[50], zero pad
  input  logic [55:0]                  s_axis_tdata,
  // master side
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // drive_current[11:0], angle_change[36:12], wanted_change[60:37], loop_active[61], zero pad
  output logic [63:0]                  m_axis_tdata,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wpic_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int DenW = wpic_pkg::CFG24_W + $clog2(HOLDER_COUNT + 1);

  // configuration registers
  logic [23:0] perimeter_q, distance_q, gain_q;
  logic [11:0] floor_q, ceiling_q;

  // sequencer and datapath
  wpic_pkg::wpic_state_e state_q, state_d;
  logic [23:0] speed_q, speed_d;
  logic [24:0] delta_q, delta_d;
  logic [23:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d, den_q, den_d;
  logic [wpic_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [wpic_pkg::PROD_W-1:0] prod_q, prod_d;
  logic neg_q, neg_d, dead_q, dead_d;
  logic run_q, run_d, estop_q, estop_d, active_q, active_d;
  logic [24:0] last_angle_q, last_angle_d;
  logic primed_q, primed_d;
  logic [27:0] target_q, target_d;
  logic [63:0] out_q, out_d;
  logic out_valid_q, out_valid_d;

  // input unpacking
  logic [23:0] in_speed;
  logic [24:0] in_angle;
  logic in_enable, in_estop, in_acc, in_run, cfg_zero;
  assign in_speed  = s_axis_tdata[23:0];
  assign in_angle  = s_axis_tdata[48:24];
  assign in_enable = s_axis_tdata[49];
  assign in_estop  = s_axis_tdata[50];

  assign s_axis_tready = (state_q == wpic_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_run        = in_enable && (in_speed >= 24'(wpic_pkg::MIN_SPEED_Q16));
  assign cfg_zero      = (perimeter_q == '0) || (distance_q == '0) || (gain_q == '0);

  // wrapped angle change
  logic signed [wpic_pkg::ERR_W-1:0] diff_raw, diff_wrap;
  always_comb begin
    diff_raw = $signed({1'b0, in_angle}) - $signed({1'b0, last_angle_q});
    if (diff_raw > $signed(26'(wpic_pkg::HALF_TURN_Q16))) begin
      diff_wrap = diff_raw - $signed(26'(wpic_pkg::FULL_TURN_Q16));
    end else if (diff_raw < -$signed(26'(wpic_pkg::HALF_TURN_Q16))) begin
      diff_wrap = diff_raw + $signed(26'(wpic_pkg::FULL_TURN_Q16));
    end else begin
      diff_wrap = diff_raw;
    end
  end

  // dividend and divisor preparation
  logic [29:0] speed36;
  logic [DenW-1:0] den_w;
  logic [wpic_pkg::DVD_W-1:0] dvd;
  assign speed36 = ({6'b0, speed_q} << 5) + ({6'b0, speed_q} << 2);
  assign den_w   = DenW'(distance_q) * DenW'(HOLDER_COUNT);
  assign dvd     = {1'b0, speed36, 16'b0} + wpic_pkg::DVD_W'(den_w[DenW-1:1]);

  // shared subtract/compare unit
  logic [DenW:0]   cmp_a;
  logic [DenW+1:0] cmp_diff;
  logic            cmp_ge;
  assign cmp_a    = (state_q == wpic_pkg::ST_CHECK) ? {1'b0, rem_q} : {rem_q, quo_q[23]};
  assign cmp_diff = {1'b0, cmp_a} - {2'b0, den_q};
  assign cmp_ge   = !cmp_diff[DenW+1];

  // error and magnitude
  logic signed [wpic_pkg::ERR_W-1:0] err;
  logic [wpic_pkg::ERR_W-1:0] err_abs;
  assign err     = $signed({2'b0, quo_q}) - $signed({delta_q[24], delta_q});
  assign err_abs = err[wpic_pkg::ERR_W-1] ? 26'(-err) : 26'(err);

  // integrator update with clamp
  logic [wpic_pkg::INC_W-1:0] inc;
  logic signed [wpic_pkg::ACC_W-1:0] acc_next, acc_clamp, ceil_ext, floor_ext;
  always_comb begin
    inc       = wpic_pkg::INC_W'((prod_q + 49'(wpic_pkg::ROUND_HALF_Q16)) >> 16);
    ceil_ext  = $signed({8'b0, ceiling_q, 16'b0});
    floor_ext = $signed({8'b0, floor_q, 16'b0});
    if (dead_q) begin
      acc_next = $signed({8'b0, target_q});
    end else if (neg_q) begin
      acc_next = $signed({8'b0, target_q}) - $signed({2'b0, inc});
    end else begin
      acc_next = $signed({8'b0, target_q}) + $signed({2'b0, inc});
    end
    acc_clamp = acc_next;
    if (acc_clamp > ceil_ext) begin
      acc_clamp = ceil_ext;
    end
    if (acc_clamp < floor_ext) begin
      acc_clamp = floor_ext;
    end
  end

  // drive from the current target
  logic [28:0] drive_sum;
  logic [11:0] drive;
  always_comb begin
    drive_sum = {1'b0, target_q} + 29'(wpic_pkg::ROUND_HALF_Q16);
    if (!(run_q && estop_q)) begin
      drive = '0;
    end else if (drive_sum[28]) begin
      drive = 12'(wpic_pkg::DRIVE_MAX);
    end else begin
      drive = drive_sum[27:16];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wpic_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_run && primed_q && !cfg_zero) ? wpic_pkg::ST_PREP : wpic_pkg::ST_OUT;
        end
      end
      wpic_pkg::ST_PREP:  state_d = wpic_pkg::ST_CHECK;
      wpic_pkg::ST_CHECK: state_d = cmp_ge ? wpic_pkg::ST_MUL : wpic_pkg::ST_DIV;
      wpic_pkg::ST_DIV: begin
        if (cnt_q == wpic_pkg::CNT_W'(wpic_pkg::DIV_STEPS - 1)) begin
          state_d = wpic_pkg::ST_MUL;
        end
      end
      wpic_pkg::ST_MUL: state_d = wpic_pkg::ST_ACC;
      wpic_pkg::ST_ACC: state_d = wpic_pkg::ST_OUT;
      wpic_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = wpic_pkg::ST_IDLE;
        end
      end
      default: state_d = wpic_pkg::ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    speed_d      = speed_q;
    delta_d      = delta_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    den_d        = den_q;
    cnt_d        = cnt_q;
    prod_d       = prod_q;
    neg_d        = neg_q;
    dead_d       = dead_q;
    run_d        = run_q;
    estop_d      = estop_q;
    active_d     = active_q;
    last_angle_d = last_angle_q;
    primed_d     = primed_q;
    target_d     = target_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    case (state_q)
      wpic_pkg::ST_IDLE: begin
        if (in_acc) begin
          speed_d  = in_speed;
          run_d    = in_run;
          estop_d  = in_estop;
          active_d = 1'b0;
          quo_d    = '0;
          delta_d  = '0;
          if (in_run) begin
            last_angle_d = in_angle;
            primed_d     = 1'b1;
            if (primed_q) begin
              delta_d = diff_wrap[24:0];
            end
          end
        end
      end
      wpic_pkg::ST_PREP: begin
        rem_d = DenW'(dvd[46:24]);
        quo_d = dvd[23:0];
        den_d = den_w;
      end
      wpic_pkg::ST_CHECK: begin
        // quotient would not fit: saturate
        if (cmp_ge) begin
          quo_d = '1;
        end
        cnt_d = '0;
      end
      wpic_pkg::ST_DIV: begin
        rem_d = cmp_ge ? cmp_diff[DenW-1:0] : cmp_a[DenW-1:0];
        quo_d = {quo_q[22:0], cmp_ge};
        cnt_d = cnt_q + wpic_pkg::CNT_W'(1);
      end
      wpic_pkg::ST_MUL: begin
        prod_d = {24'b0, err_abs[wpic_pkg::MAG_W-1:0]} * {25'b0, gain_q};
        neg_d  = err[wpic_pkg::ERR_W-1];
        dead_d = (err <= $signed(26'(wpic_pkg::DEADBAND_Q16)))
              && (err >= -$signed(26'(wpic_pkg::DEADBAND_Q16)));
      end
      wpic_pkg::ST_ACC: begin
        target_d = acc_clamp[27:0];
        active_d = 1'b1;
      end
      wpic_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = {2'b0, active_q, quo_q, delta_q, drive};
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // sequencer, state and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= wpic_pkg::ST_IDLE;
      last_angle_q <= '0;
      primed_q     <= 1'b0;
      target_q     <= 28'(wpic_pkg::RESET_CURRENT);
      out_valid_q  <= 1'b0;
      run_q        <= 1'b0;
      estop_q      <= 1'b0;
      active_q     <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      last_angle_q <= last_angle_d;
      primed_q     <= primed_d;
      target_q     <= target_d;
      out_valid_q  <= out_valid_d;
      run_q        <= run_d;
      estop_q      <= estop_d;
      active_q     <= active_d;
      cnt_q        <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    speed_q <= speed_d;
    delta_q <= delta_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    prod_q  <= prod_d;
    neg_q   <= neg_d;
    dead_q  <= dead_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // configuration writes
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perimeter_q <= '0;
      distance_q  <= '0;
      gain_q      <= '0;
      floor_q     <= wpic_pkg::FLOOR_RST;
      ceiling_q   <= wpic_pkg::CEILING_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        wpic_pkg::REG_PERIMETER: perimeter_q <= pwdata[23:0];
        wpic_pkg::REG_DISTANCE:  distance_q  <= pwdata[23:0];
        wpic_pkg::REG_GAIN:      gain_q      <= pwdata[23:0];
        wpic_pkg::REG_FLOOR:     floor_q     <= pwdata[11:0];
        wpic_pkg::REG_CEILING:   ceiling_q   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    case (paddr[4:2])
      wpic_pkg::REG_PERIMETER: prdata = {8'b0, perimeter_q};
      wpic_pkg::REG_DISTANCE:  prdata = {8'b0, distance_q};
      wpic_pkg::REG_GAIN:      prdata = {8'b0, gain_q};
      wpic_pkg::REG_FLOOR:     prdata = {20'b0, floor_q};
      wpic_pkg::REG_CEILING:   prdata = {20'b0, ceiling_q};
      default:                 prdata = '0;
    endcase
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input taken again right after accept");

  a_div_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wpic_pkg::ST_DIV) |-> (cnt_q < wpic_pkg::CNT_W'(wpic_pkg::DIV_STEPS)))
    else $error("divider step count out of range");

  a_primed_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(primed_q))
    else $error("primed flag cleared outside reset");

  a_active_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wpic_pkg::ST_ACC) |-> (run_q && !cfg_zero))
    else $error("integrator update on a gated tick");

endmodule
